// File: rtl/cbs_pkg.sv
// Package for the crossover band splitter: register codes, sequencer states,
// section coefficient selectors and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package cbs_pkg;

    localparam int SLOTS_PER_CHANNEL = 28;
    localparam int SAMPLE_W = 24;
    localparam int SIG_W = 32;
    localparam int ST_W = 48;
    localparam int COEF_W = 32;
    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh4000_0000;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_BAND_COUNT = 3'd0,
        REG_GAMMA_LOW  = 3'd1,
        REG_DELTA_LOW  = 3'd2,
        REG_GAMMA_MID  = 3'd3,
        REG_DELTA_MID  = 3'd4,
        REG_GAMMA_HIGH = 3'd5,
        REG_DELTA_HIGH = 3'd6,
        REG_UNUSED     = 3'd7
    } t_reg_idx;

    // Which crossover a section takes its coefficients from.
    typedef enum logic [1:0] {
        XO_LOW  = 2'd0,
        XO_MID  = 2'd1,
        XO_HIGH = 2'd2
    } t_xover;

    // Which coefficient set of a crossover.
    typedef enum logic [1:0] {
        KIND_LP = 2'd0,
        KIND_HP = 2'd1,
        KIND_AP = 2'd2
    } t_kind;

    // Signal source for a section input.
    typedef enum logic [2:0] {
        SRC_SAMPLE = 3'd0,
        SRC_PREV   = 3'd1,
        SRC_LOW    = 3'd2,
        SRC_HIGH   = 3'd3,
        SRC_ALOW   = 3'd4,
        SRC_AHIGH  = 3'd5
    } t_src;

    // Where a section output is kept.
    typedef enum logic [2:0] {
        DST_PREV  = 3'd0,
        DST_LOW   = 3'd1,
        DST_HIGH  = 3'd2,
        DST_ALOW  = 3'd3,
        DST_AHIGH = 3'd4,
        DST_B0    = 3'd5,
        DST_B1    = 3'd6,
        DST_B2    = 3'd7
    } t_dst;

    // Section descriptor; band three is written through the to_b3 flag on a DST_PREV section.
    typedef struct packed {
        t_xover     xo;
        t_kind      kind;
        t_src       src;
        t_dst       dst;
        logic       to_b3;
        logic [4:0] slot;
    } t_sec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_M0,
        S_Y,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_ST0,
        S_ST1,
        S_WR,
        S_DONE
    } t_state;

    // Section program for each mode. Index counts sections in run order.
    function automatic t_sec sec_prog(input logic [1:0] mode, input logic [3:0] idx);
        t_sec s;
        s = '{xo: XO_LOW, kind: KIND_LP, src: SRC_SAMPLE, dst: DST_PREV,
              to_b3: 1'b0, slot: 5'd0};
        unique case (mode)
            2'd1: begin
                unique case (idx)
                    4'd0: s = '{XO_LOW, KIND_LP, SRC_SAMPLE, DST_PREV, 1'b0, 5'd0};
                    4'd1: s = '{XO_LOW, KIND_LP, SRC_PREV, DST_B0, 1'b0, 5'd2};
                    4'd2: s = '{XO_LOW, KIND_HP, SRC_SAMPLE, DST_PREV, 1'b0, 5'd4};
                    default: s = '{XO_LOW, KIND_HP, SRC_PREV, DST_B1, 1'b0, 5'd6};
                endcase
            end
            2'd2: begin
                unique case (idx)
                    4'd0: s = '{XO_MID, KIND_LP, SRC_SAMPLE, DST_PREV, 1'b0, 5'd0};
                    4'd1: s = '{XO_MID, KIND_LP, SRC_PREV, DST_LOW, 1'b0, 5'd2};
                    4'd2: s = '{XO_MID, KIND_HP, SRC_SAMPLE, DST_PREV, 1'b0, 5'd4};
                    4'd3: s = '{XO_MID, KIND_HP, SRC_PREV, DST_HIGH, 1'b0, 5'd6};
                    4'd4: s = '{XO_LOW, KIND_AP, SRC_HIGH, DST_B2, 1'b0, 5'd10};
                    4'd5: s = '{XO_LOW, KIND_LP, SRC_LOW, DST_PREV, 1'b0, 5'd12};
                    4'd6: s = '{XO_LOW, KIND_LP, SRC_PREV, DST_B0, 1'b0, 5'd14};
                    4'd7: s = '{XO_LOW, KIND_HP, SRC_LOW, DST_PREV, 1'b0, 5'd16};
                    default: s = '{XO_LOW, KIND_HP, SRC_PREV, DST_B1, 1'b0, 5'd18};
                endcase
            end
            default: begin
                unique case (idx)
                    4'd0: s = '{XO_MID, KIND_LP, SRC_SAMPLE, DST_PREV, 1'b0, 5'd0};
                    4'd1: s = '{XO_MID, KIND_LP, SRC_PREV, DST_LOW, 1'b0, 5'd2};
                    4'd2: s = '{XO_MID, KIND_HP, SRC_SAMPLE, DST_PREV, 1'b0, 5'd4};
                    4'd3: s = '{XO_MID, KIND_HP, SRC_PREV, DST_HIGH, 1'b0, 5'd6};
                    4'd4: s = '{XO_HIGH, KIND_AP, SRC_LOW, DST_ALOW, 1'b0, 5'd8};
                    4'd5: s = '{XO_LOW, KIND_AP, SRC_HIGH, DST_AHIGH, 1'b0, 5'd10};
                    4'd6: s = '{XO_LOW, KIND_LP, SRC_ALOW, DST_PREV, 1'b0, 5'd12};
                    4'd7: s = '{XO_LOW, KIND_LP, SRC_PREV, DST_B0, 1'b0, 5'd14};
                    4'd8: s = '{XO_LOW, KIND_HP, SRC_ALOW, DST_PREV, 1'b0, 5'd16};
                    4'd9: s = '{XO_LOW, KIND_HP, SRC_PREV, DST_B1, 1'b0, 5'd18};
                    4'd10: s = '{XO_HIGH, KIND_LP, SRC_AHIGH, DST_PREV, 1'b0, 5'd20};
                    4'd11: s = '{XO_HIGH, KIND_LP, SRC_PREV, DST_B2, 1'b0, 5'd22};
                    4'd12: s = '{XO_HIGH, KIND_HP, SRC_AHIGH, DST_PREV, 1'b0, 5'd24};
                    default: s = '{XO_HIGH, KIND_HP, SRC_PREV, DST_PREV, 1'b1, 5'd26};
                endcase
            end
        endcase
        return s;
    endfunction

    // Number of sections less one for each mode.
    function automatic logic [3:0] sec_last(input logic [1:0] mode);
        logic [3:0] r;
        unique case (mode)
            2'd1: r = 4'd3;
            2'd2: r = 4'd8;
            default: r = 4'd13;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'sd8388607) begin
            r = 24'sh7F_FFFF;
        end else if (v < -32'sd8388608) begin
            r = 24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/crossover_band_splitter_unit.sv
// Top level of the crossover band splitter: APB registers, state memory,
// section sequencer around the shared multiplier. Uses cbs_pkg and cbs_mac.
//
//  Channel   Signals                               Direction
//  input     i_valid/o_ready, i_channel, i_sample  in
//  output    o_valid/i_ready, o_band_*             out
//  config    psel..pready, prdata                  APB
//
// Each biquad section runs two reads, eight MAC steps (the first state word
// written back in S_ST0) and one write. Two bands run 4 sections, three bands 9
// and four or more bands 14; a band count of zero or one passes the sample
// through. The single multiplier and the one-port state memory set the pace.
// Reset initialises the configuration and sequencer registers, then a clearing
// pass zeroes all CHANNELS*28 words of the state memory; no request is taken
// during it. A stalled result holds the block until it is taken.
`timescale 1ns / 1ps
module crossover_band_splitter_unit #(
    parameter int CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_channel,
    input  logic signed [23:0] i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [23:0] o_band_zero,
    output logic signed [23:0] o_band_one,
    output logic signed [23:0] o_band_two,
    output logic signed [23:0] o_band_three,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbs_pkg::*;

    localparam int DEPTH = CHANNELS * SLOTS_PER_CHANNEL;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [ST_W+1:0] ACC_MAX = 50'sd140737488355327;
    localparam logic signed [ST_W+1:0] ACC_MIN = -50'sd140737488355328;

    // Configuration registers.
    logic [2:0]         r_band_count;
    logic signed [31:0] r_gl, r_dl, r_gm, r_dm, r_gh, r_dh;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_count <= 3'd1;
            r_gl <= '0; r_dl <= '0; r_gm <= '0; r_dm <= '0; r_gh <= '0; r_dh <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_BAND_COUNT: r_band_count <= pwdata[2:0];
                REG_GAMMA_LOW:  r_gl <= pwdata;
                REG_DELTA_LOW:  r_dl <= pwdata;
                REG_GAMMA_MID:  r_gm <= pwdata;
                REG_DELTA_MID:  r_dm <= pwdata;
                REG_GAMMA_HIGH: r_gh <= pwdata;
                REG_DELTA_HIGH: r_dh <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BAND_COUNT: prdata = {29'd0, r_band_count};
            REG_GAMMA_LOW:  prdata = r_gl;
            REG_DELTA_LOW:  prdata = r_dl;
            REG_GAMMA_MID:  prdata = r_gm;
            REG_DELTA_MID:  prdata = r_dm;
            REG_GAMMA_HIGH: prdata = r_gh;
            REG_DELTA_HIGH: prdata = r_dh;
            default:        prdata = '0;
        endcase
    end

    // Sequencer registers.
    t_state r_state, n_state;
    logic [AW:0]        r_clr;
    logic               r_clearing;
    logic [1:0]         r_mode;
    logic [3:0]         r_sec;
    logic [AW-1:0]      r_base;
    logic signed [31:0] r_x, r_prev, r_low, r_high, r_alow, r_ahigh, r_y;
    logic signed [31:0] r_b0, r_b1, r_b2, r_b3;
    logic signed [ST_W-1:0] r_s0, r_s1, r_n0;
    logic               r_out_valid;

    // Current section and its coefficients.
    t_sec               sec;
    logic signed [31:0] g, d, c_b0, c_b1, c_b2, c_a1, c_a2, sig_in;
    logic signed [35:0] a1_w, a2_w, lp1_w, hp1_w;

    always_comb begin
        sec = sec_prog(r_mode, r_sec);
        unique case (sec.xo)
            XO_LOW:  begin g = r_gl; d = r_dl; end
            XO_MID:  begin g = r_gm; d = r_dm; end
            default: begin g = r_gh; d = r_dh; end
        endcase
        a1_w  = 36'(2) * (36'(g) - 36'(d));
        a2_w  = 36'(2) * (36'(g) + 36'(d)) - 36'(COEF_ONE);
        lp1_w = 36'(2) * 36'(g);
        hp1_w = -36'(2) * 36'(d);
        c_a1 = sat32(a1_w);
        c_a2 = sat32(a2_w);
        unique case (sec.kind)
            KIND_LP: begin c_b0 = g; c_b1 = sat32(lp1_w); c_b2 = g; end
            KIND_HP: begin c_b0 = d; c_b1 = sat32(hp1_w); c_b2 = d; end
            default: begin c_b0 = c_a2; c_b1 = c_a1; c_b2 = COEF_ONE; end
        endcase
        unique case (sec.src)
            SRC_SAMPLE: sig_in = r_x;
            SRC_PREV:   sig_in = r_prev;
            SRC_LOW:    sig_in = r_low;
            SRC_HIGH:   sig_in = r_high;
            SRC_ALOW:   sig_in = r_alow;
            default:    sig_in = r_ahigh;
        endcase
    end

    // State memory, one port, registered read.
    logic signed [ST_W-1:0] mem [DEPTH];
    logic signed [ST_W-1:0] r_rd;
    logic [AW-1:0]          mem_addr;
    logic                   mem_we;
    logic signed [ST_W-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rd <= mem[mem_addr];
    end

    // Shared MAC.
    logic mac_clear, mac_en, mac_sub;
    logic signed [31:0] mac_coef, mac_sig;
    logic signed [ST_W+1:0] mac_base, mac_acc;

    cbs_mac u_mac (
        .i_clk   (i_clk),
        .i_clear (mac_clear),
        .i_en    (mac_en),
        .i_sub   (mac_sub),
        .i_coef  (mac_coef),
        .i_sig   (mac_sig),
        .i_base  (mac_base),
        .o_acc   (mac_acc)
    );

    // Saturated state and rounded section output.
    logic signed [ST_W-1:0] acc_sat;
    logic signed [ST_W+1:0] acc_rnd;
    logic signed [35:0]     y_w;
    always_comb begin
        if (mac_acc > ACC_MAX) begin
            acc_sat = {1'b0, {(ST_W-1){1'b1}}};
        end else if (mac_acc < ACC_MIN) begin
            acc_sat = {1'b1, {(ST_W-1){1'b0}}};
        end else begin
            acc_sat = mac_acc[ST_W-1:0];
        end
        acc_rnd = mac_acc + (ST_W+2)'(16384);
        y_w = 36'(acc_rnd >>> 15);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && !r_clearing && !r_out_valid) begin
                if (i_channel >= 3'(CHANNELS) && CHANNELS < 8) n_state = S_DONE;
                else if (r_band_count <= 3'd1) n_state = S_DONE;
                else n_state = S_RD0;
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_M0;
            S_M0:  n_state = S_Y;
            S_Y:   n_state = S_M1;
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_M3;
            S_M3:  n_state = S_M4;
            S_M4:  n_state = S_ST0;
            S_ST0: n_state = S_ST1;
            S_ST1: n_state = S_WR;
            S_WR:  n_state = (r_sec == sec_last(r_mode)) ? S_DONE : S_RD0;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath controls. The first state word goes back in S_ST0, the
    // second in S_WR.
    always_comb begin
        mac_clear = 1'b0; mac_en = 1'b0; mac_sub = 1'b0;
        mac_coef = c_b0; mac_sig = sig_in; mac_base = '0;
        mem_we = 1'b0; mem_wd = '0;
        mem_addr = r_base + AW'(sec.slot);
        unique case (r_state)
            S_RD0: mem_addr = r_base + AW'(sec.slot);
            S_RD1: mem_addr = r_base + AW'(sec.slot) + AW'(1);
            S_M0: begin
                mac_clear = 1'b1; mac_base = (ST_W+2)'(r_s0);
                mac_en = 1'b1; mac_coef = c_b0;
            end
            S_Y: ;
            S_M1: begin
                mac_clear = 1'b1; mac_base = (ST_W+2)'(r_s1);
                mac_en = 1'b1; mac_coef = c_b1;
            end
            S_M2: begin mac_en = 1'b1; mac_sub = 1'b1; mac_coef = c_a1; mac_sig = r_y; end
            S_M3: ;
            S_M4: begin
                mac_clear = 1'b1; mac_en = 1'b1; mac_coef = c_b2;
            end
            S_ST0: begin
                mac_en = 1'b1; mac_sub = 1'b1; mac_coef = c_a2; mac_sig = r_y;
                mem_we = 1'b1; mem_wd = r_n0;
                mem_addr = r_base + AW'(sec.slot);
            end
            S_ST1: ;
            S_WR: begin
                mem_we = 1'b1; mem_wd = acc_sat;
                mem_addr = r_base + AW'(sec.slot) + AW'(1);
            end
            default: ;
        endcase
        if (r_clearing) begin
            mem_we = 1'b1; mem_wd = '0; mem_addr = r_clr[AW-1:0];
        end
    end

    // Sequencer registers update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_sec       <= '0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr <= r_clr + (AW+1)'(1);
                if (r_clr == (AW+1)'(DEPTH - 1)) r_clearing <= 1'b0;
            end
            if (r_state == S_IDLE && n_state != S_IDLE) r_sec <= '0;
            if (r_state == S_WR && n_state == S_RD0) r_sec <= r_sec + 4'd1;
            if (r_state == S_DONE) r_out_valid <= 1'b1;
            else if (o_valid && i_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers; the bands hold while a result waits.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (o_ready) begin
                r_x    <= 32'(i_sample);
                r_base <= AW'(i_channel) * AW'(SLOTS_PER_CHANNEL);
                r_mode <= (r_band_count >= 3'd4) ? 2'd3 : r_band_count[1:0] - 2'd1;
                r_b0 <= ((r_band_count <= 3'd1) &&
                         !(i_channel >= 3'(CHANNELS) && CHANNELS < 8)) ?
                        32'(i_sample) : '0;
                r_b1 <= '0; r_b2 <= '0; r_b3 <= '0;
            end
            S_RD1: ;
            S_M0:  r_s1 <= r_rd;
            S_Y:   ;
            S_M1:  r_y <= sat32(y_w);
            S_M4:  r_n0 <= acc_sat;
            S_ST1: ;
            S_WR:  ;
            default: ;
        endcase
        if (r_state == S_RD1) r_s0 <= r_rd;
        if (r_state == S_WR) begin
            unique case (sec.dst)
                DST_PREV:  if (sec.to_b3) r_b3 <= r_y; else r_prev <= r_y;
                DST_LOW:   r_low <= r_y;
                DST_HIGH:  r_high <= r_y;
                DST_ALOW:  r_alow <= r_y;
                DST_AHIGH: r_ahigh <= r_y;
                DST_B0:    r_b0 <= r_y;
                DST_B1:    r_b1 <= r_y;
                default:   r_b2 <= r_y;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE) && !r_clearing && !r_out_valid;
    assign o_valid      = r_out_valid;
    assign o_band_zero  = sat24(r_b0);
    assign o_band_one   = sat24(r_b1);
    assign o_band_two   = sat24(r_b2);
    assign o_band_three = sat24(r_b3);

endmodule

// File: rtl/cbs_mac.sv
// Shared multiply-accumulate unit: one 32x32 product per cycle, floor shift
// by 15, registered and added to or subtracted from a 50 bit accumulator. Uses cbs_pkg.
`timescale 1ns / 1ps
module cbs_mac (
    input  logic                                i_clk,
    input  logic                                i_clear,
    input  logic                                i_en,
    input  logic                                i_sub,
    input  logic signed [cbs_pkg::COEF_W-1:0]   i_coef,
    input  logic signed [cbs_pkg::SIG_W-1:0]    i_sig,
    input  logic signed [cbs_pkg::ST_W+1:0]     i_base,
    output logic signed [cbs_pkg::ST_W+1:0]     o_acc
);
    import cbs_pkg::*;

    logic signed [63:0]   n_prod;
    logic signed [48:0]   r_term;
    logic                 r_valid;
    logic                 r_sub;
    logic signed [ST_W+1:0] r_acc;

    // Product stage: exact product, floor shift keeps 49 bits.
    always_comb begin
        n_prod = i_coef * i_sig;
    end

    always_ff @(posedge i_clk) begin
        r_term  <= n_prod[63:15];
        r_valid <= i_en;
        r_sub   <= i_sub;
    end

    // Accumulate stage; a clear loads the base value.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= i_base;
        end else if (r_valid) begin
            if (r_sub) begin
                r_acc <= r_acc - (ST_W+2)'(r_term);
            end else begin
                r_acc <= r_acc + (ST_W+2)'(r_term);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for crossover_band_splitter_unit: predicts every band
// result in fixed point and checks the results in order. Depends on cbs_pkg.
`timescale 1ns / 1ps
module testbench;
    import cbs_pkg::*;

    localparam int NCH = 8;
    localparam longint S48_HI = 64'sd140737488355327;
    localparam longint S48_LO = -64'sd140737488355328;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam int CYCLE_LIMIT = 2000000;

    typedef longint coefs_t [5];
    typedef struct {
        logic signed [23:0] b0;
        logic signed [23:0] b1;
        logic signed [23:0] b2;
        logic signed [23:0] b3;
    } bands_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [2:0] i_channel = '0;
    logic signed [23:0] i_sample = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [23:0] o_band_zero, o_band_one, o_band_two, o_band_three;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    crossover_band_splitter_unit #(.CHANNELS(NCH)) dut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow registers and filter memory of the predictor.
    logic [2:0] bands_reg = 3'd1;
    longint xo_gamma [3];
    longint xo_delta [3];
    longint filt_mem [NCH][SLOTS_PER_CHANNEL];

    bands_t expected_bands [$];
    int mismatches = 0;
    int cycles = 0;
    int hold_request = 0;

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mul_q(input longint c, input longint s);
        longint p;
        p = c * s;
        return p >>> 15;
    endfunction

    // Derive low-pass, high-pass and all-pass coefficients of one crossover.
    function automatic void derive_coefs(input int xo, output coefs_t lp, output coefs_t hp,
                                         output coefs_t ap);
        longint g, d, a1, a2;
        g = xo_gamma[xo];
        d = xo_delta[xo];
        a1 = clip(2 * (g - d), S32_LO, S32_HI);
        a2 = clip(2 * (g + d) - ONE_Q30, S32_LO, S32_HI);
        lp = '{g, clip(2 * g, S32_LO, S32_HI), g, a1, a2};
        hp = '{d, clip(-2 * d, S32_LO, S32_HI), d, a1, a2};
        ap = '{a2, a1, ONE_Q30, a1, a2};
    endfunction

    // One transposed biquad section on two memory words.
    function automatic longint run_biquad(input coefs_t k, input int ch, input int sl,
                                          input longint x);
        longint acc, y;
        acc = filt_mem[ch][sl] + mul_q(k[0], x);
        y = clip((acc + 16384) >>> 15, S32_LO, S32_HI);
        filt_mem[ch][sl] = clip(filt_mem[ch][sl+1] + mul_q(k[1], x) - mul_q(k[3], y),
                                S48_LO, S48_HI);
        filt_mem[ch][sl+1] = clip(mul_q(k[2], x) - mul_q(k[4], y), S48_LO, S48_HI);
        return y;
    endfunction

    function automatic void split_band(input coefs_t lp, input coefs_t hp, input int ch,
                                       input int sl, input longint x, output longint lo,
                                       output longint hi);
        longint t;
        t = run_biquad(lp, ch, sl, x);
        lo = run_biquad(lp, ch, sl + 2, t);
        t = run_biquad(hp, ch, sl + 4, x);
        hi = run_biquad(hp, ch, sl + 6, t);
    endfunction

    // Expected bands for one accepted request.
    function automatic bands_t predict_bands(input logic [2:0] ch, input logic signed [23:0] s);
        coefs_t llp, lhp, lap, mlp, mhp, map, hlp, hhp, hap;
        longint band [4];
        longint x, l, h;
        int n, c;
        bands_t r;
        band = '{0, 0, 0, 0};
        x = s;
        c = ch;
        n = (bands_reg == 3'd0) ? 1 : (bands_reg > 3'd4 ? 4 : int'(bands_reg));
        derive_coefs(0, llp, lhp, lap);
        derive_coefs(1, mlp, mhp, map);
        derive_coefs(2, hlp, hhp, hap);
        if (c < NCH) begin
            if (n == 1) begin
                band[0] = x;
            end else if (n == 2) begin
                split_band(llp, lhp, c, 0, x, band[0], band[1]);
            end else if (n == 3) begin
                split_band(mlp, mhp, c, 0, x, l, h);
                band[2] = run_biquad(lap, c, 10, h);
                split_band(llp, lhp, c, 12, l, band[0], band[1]);
            end else begin
                split_band(mlp, mhp, c, 0, x, l, h);
                l = run_biquad(hap, c, 8, l);
                h = run_biquad(lap, c, 10, h);
                split_band(llp, lhp, c, 12, l, band[0], band[1]);
                split_band(hlp, hhp, c, 20, h, band[2], band[3]);
            end
        end
        r.b0 = 24'(clip(band[0], -64'sd8388608, 64'sd8388607));
        r.b1 = 24'(clip(band[1], -64'sd8388608, 64'sd8388607));
        r.b2 = 24'(clip(band[2], -64'sd8388608, 64'sd8388607));
        r.b3 = 24'(clip(band[3], -64'sd8388608, 64'sd8388607));
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
    endfunction

    // Register write through the configuration port; the shadow copy follows.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 5'(idx) << 2;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_BAND_COUNT: bands_reg = value[2:0];
            REG_GAMMA_LOW:  xo_gamma[0] = longint'(signed'(value));
            REG_DELTA_LOW:  xo_delta[0] = longint'(signed'(value));
            REG_GAMMA_MID:  xo_gamma[1] = longint'(signed'(value));
            REG_DELTA_MID:  xo_delta[1] = longint'(signed'(value));
            REG_GAMMA_HIGH: xo_gamma[2] = longint'(signed'(value));
            REG_DELTA_HIGH: xo_delta[2] = longint'(signed'(value));
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [2:0] n, input logic [31:0] gl, input logic [31:0] dl,
                             input logic [31:0] gm, input logic [31:0] dm,
                             input logic [31:0] gh, input logic [31:0] dh);
        write_reg(REG_BAND_COUNT, 32'(n));
        write_reg(REG_GAMMA_LOW, gl);
        write_reg(REG_DELTA_LOW, dl);
        write_reg(REG_GAMMA_MID, gm);
        write_reg(REG_DELTA_MID, dm);
        write_reg(REG_GAMMA_HIGH, gh);
        write_reg(REG_DELTA_HIGH, dh);
    endtask

    // Offer one request and record its prediction when accepted.
    task automatic send_sample(input logic [2:0] ch, input logic signed [23:0] s,
                               input bit no_gap);
        int gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_channel = ch;
        i_sample = s;
        do @(posedge i_clk); while (!o_ready);
        expected_bands.push_back(predict_bands(ch, s));
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (expected_bands.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Moderate coefficients that keep the filters mostly in range.
    function automatic logic [31:0] soft_coef();
        return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    endfunction

    function automatic logic [31:0] any_coef();
        return ($urandom_range(0, 3) == 0) ? $urandom() : soft_coef();
    endfunction

    // Result side: random ready, with a long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                i_ready = 1'b0;
                hold_request = hold_request - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_ready = 1'b1;
            end else begin
                i_ready = ($urandom_range(0, 9) < 7);
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        bands_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bands.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h %h %h",
                    o_band_zero, o_band_one, o_band_two, o_band_three);
            end else begin
                e = expected_bands.pop_front();
                if (o_band_zero !== e.b0 || o_band_one !== e.b1 ||
                    o_band_two !== e.b2 || o_band_three !== e.b3) begin
                    mismatches++;
                    if (mismatches <= 10) $display(
                        "mismatch: expected %h %h %h %h, got %h %h %h %h",
                        e.b0, e.b1, e.b2, e.b3,
                        o_band_zero, o_band_one, o_band_two, o_band_three);
                end
            end
        end
    end

    // Pass-through after reset with extreme and small samples on channels 0, 7, 5 and 2.
    task automatic test_reset_passthrough();
        send_sample(3'd0, 24'sh7F_FFFF, 1'b0);
        send_sample(3'd7, 24'sh80_0000, 1'b0);
        send_sample(3'd5, 24'sh00_0000, 1'b0);
        send_sample(3'd2, 24'shFF_FFFF, 1'b0);
        drain();
    endtask

    // Each band count, including zero and counts above four, at extremes.
    task automatic test_band_modes();
        logic [2:0] n;
        for (int m = 0; m < 8; m++) begin
            n = 3'(m);
            if (m == 6) begin
                write_all(n, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            end else begin
                write_all(n, soft_coef(), soft_coef(), soft_coef(),
                          soft_coef(), soft_coef(), soft_coef());
            end
            send_sample(3'(m), 24'sh7F_FFFF, 1'b0);
            send_sample(3'(m), 24'sh80_0000, 1'b0);
            drain();
        end
    endtask

    // Random phases over all settings, most in the split modes.
    task automatic test_random_phases();
        for (int p = 0; p < 12; p++) begin
            write_all(3'($urandom_range(0, 7)), any_coef(), any_coef(), any_coef(),
                      any_coef(), any_coef(), any_coef());
            repeat (28) send_sample(3'($urandom_range(0, 7)), 24'($urandom()), 1'b0);
            drain();
        end
    endtask

    // Receiver holds off while requests keep coming, then the sender pauses.
    task automatic test_backpressure();
        write_all(3'd2, soft_coef(), soft_coef(), soft_coef(),
                  soft_coef(), soft_coef(), soft_coef());
        hold_request = 600;
        repeat (12) send_sample(3'($urandom_range(0, 7)), 24'($urandom()), 1'b1);
        drain();
        repeat (10) send_sample(3'($urandom_range(0, 7)), 24'($urandom()), 1'b0);
        drain();
    endtask

    initial begin
        xo_gamma = '{0, 0, 0};
        xo_delta = '{0, 0, 0};
        foreach (filt_mem[c, s]) filt_mem[c][s] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_passthrough();
        test_band_modes();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (250) @(posedge i_clk);
        if (mismatches == 0 && expected_bands.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// File: crossover_band_splitter_unit.f
rtl/cbs_pkg.sv
rtl/cbs_mac.sv
rtl/crossover_band_splitter_unit.sv
tb/testbench.sv
